/* sv/smc_pkg.sv */
// Package for the stack machine core: sizes, opcodes, status codes,
// beat structs, controller states and the controller-datapath command/status types.
// Depends on nothing.
package smc_pkg;

    localparam int PROG_DEPTH  = 1024;
    localparam int PROG_AW     = $clog2(PROG_DEPTH);
    localparam int PC_W        = $clog2(PROG_DEPTH + 1);
    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [4:0] OP_HLT = 5'd0;
    localparam logic [4:0] OP_PSH = 5'd1;
    localparam logic [4:0] OP_DUP = 5'd2;
    localparam logic [4:0] OP_ADD = 5'd3;
    localparam logic [4:0] OP_SUB = 5'd4;
    localparam logic [4:0] OP_MUL = 5'd5;
    localparam logic [4:0] OP_DIV = 5'd6;
    localparam logic [4:0] OP_MOD = 5'd7;
    localparam logic [4:0] OP_PRN = 5'd8;
    localparam logic [4:0] OP_EQ  = 5'd9;
    localparam logic [4:0] OP_GT  = 5'd10;
    localparam logic [4:0] OP_LT  = 5'd11;
    localparam logic [4:0] OP_GEQ = 5'd12;
    localparam logic [4:0] OP_LEQ = 5'd13;
    localparam logic [4:0] OP_JMP = 5'd14;
    localparam logic [4:0] OP_JZ  = 5'd15;
    localparam logic [4:0] OP_JNZ = 5'd16;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_HALT = 3'd1;
    localparam logic [2:0] ST_END  = 3'd2;
    localparam logic [2:0] ST_OVF  = 3'd3;
    localparam logic [2:0] ST_UNF  = 3'd4;
    localparam logic [2:0] ST_DIV0 = 3'd5;
    localparam logic [2:0] ST_JMP  = 3'd6;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         address;
        logic signed [31:0] word;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [10:0]        program_counter;
        logic [8:0]         stack_depth;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_OP, S_DEC, S_ARG, S_ARG2, S_JT,
        S_DUP, S_PRN, S_RDY, S_RDX, S_ALU, S_DIV, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        WS_ARG, WS_STK, WS_ALU, WS_DIV
    } wsel_t;

    typedef struct packed {
        logic       start;
        logic       prog_wr;
        logic       prog_rd;
        logic       pc_inc;
        logic       pc_clear;
        logic       pc_load;
        logic       latch_op;
        logic       latch_arg;
        logic       stk_rd;
        logic       stk_rd_second;
        logic       stk_wr;
        wsel_t      wr_sel;
        logic       sp_inc;
        logic       sp_dec;
        logic       sp_dec2;
        logic       set_status;
        logic [2:0] status_code;
        logic       div_start;
        logic       print_set;
        logic       latch_y;
        logic       latch_x;
        logic       rsp_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] op;
        logic       op_small;
        logic       pc_end;
        logic       sp_zero;
        logic       sp_one;
        logic       sp_full;
        logic       jump_bad;
        logic       rd_zero;
        logic       y_zero;
        logic       div_done;
    } stat_t;

endpackage

/* sv/smc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* sv/smc_divider.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on smc_pkg.
module smc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [smc_pkg::WORD_W-1:0]  dividend,
    input  logic [smc_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [smc_pkg::WORD_W-1:0]  quotient,
    output logic [smc_pkg::WORD_W-1:0]  remainder
);
    import smc_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic [WORD_W:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            quo_next  = dividend[WORD_W-1] ? -dividend : dividend;
            dvs_next  = divisor[WORD_W-1] ? -divisor : divisor;
            rem_next  = '0;
            qneg_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rneg_next = dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? -quo_reg : quo_reg;
    assign remainder = rneg_reg ? -rem_reg : rem_reg;
endmodule

/* sv/smc_datapath.sv */
// Datapath of the stack machine: program and stack memories, pc, stack pointer,
// operand registers, ALU, divider and result register. Depends on smc_pkg, smc_ram, smc_divider.
module smc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smc_pkg::req_t        req_data,
    input  logic                 cfg_write_enable,
    input  logic [10:0]          cfg_write_data,
    input  smc_pkg::cmd_t        cmd,
    output smc_pkg::stat_t       stat,
    output smc_pkg::rsp_t        rsp_data
);
    import smc_pkg::*;

    req_t              req_reg;
    logic [PC_W-1:0]   len_reg;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [2:0]        status_reg;
    logic              pvalid_reg;
    logic [WORD_W-1:0] pvalue_reg;
    logic [WORD_W-1:0] op_reg, arg_reg, x_reg, y_reg;
    rsp_t              rsp_reg;

    logic [WORD_W-1:0] prog_rdata, stk_rdata, stk_wdata, alu, quo, rem;
    logic [PC_W-1:0]   eff_len;
    logic [SP_W-1:0]   sp_m1, sp_m2, stk_raddr;
    logic              div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pc_reg  <= '0;
            sp_reg  <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                len_reg <= cfg_write_data;
            end
            pc_reg <= pc_next;
            sp_reg <= sp_next;
        end
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (cmd.pc_clear)
        begin
            pc_next = '0;
        end
        else if (cmd.pc_load)
        begin
            pc_next = arg_reg[PC_W-1:0];
        end
        else if (cmd.pc_inc)
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.sp_inc)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (cmd.sp_dec)
        begin
            sp_next = sp_m1;
        end
        else if (cmd.sp_dec2)
        begin
            sp_next = sp_m2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg    <= req_data;
            status_reg <= ST_RUN;
            pvalid_reg <= 1'b0;
            pvalue_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.print_set)
        begin
            pvalid_reg <= 1'b1;
            pvalue_reg <= stk_rdata;
        end
        if (cmd.latch_op)
        begin
            op_reg <= prog_rdata;
        end
        if (cmd.latch_arg)
        begin
            arg_reg <= prog_rdata;
        end
        if (cmd.latch_y)
        begin
            y_reg <= stk_rdata;
        end
        if (cmd.latch_x)
        begin
            x_reg <= stk_rdata;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.status          <= status_reg;
            rsp_reg.print_valid     <= pvalid_reg;
            rsp_reg.print_value     <= pvalue_reg;
            rsp_reg.program_counter <= pc_reg;
            rsp_reg.stack_depth     <= sp_reg;
        end
    end

    assign eff_len   = (len_reg > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : len_reg;
    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_m2     = sp_reg - SP_W'(2);
    assign stk_raddr = cmd.stk_rd_second ? sp_m2 : sp_m1;

    smc_ram #(.WIDTH(WORD_W), .DEPTH(PROG_DEPTH)) u_prog (
        .clk     (clk),
        .wr_en   (cmd.prog_wr),
        .wr_addr (req_reg.address),
        .wr_data (req_reg.word),
        .rd_en   (cmd.prog_rd),
        .rd_addr (pc_reg[PROG_AW-1:0]),
        .rd_data (prog_rdata)
    );

    always_comb
    begin
        case (cmd.wr_sel)
            WS_ARG:  stk_wdata = arg_reg;
            WS_STK:  stk_wdata = stk_rdata;
            WS_ALU:  stk_wdata = alu;
            WS_DIV:  stk_wdata = (op_reg[4:0] == OP_DIV) ? quo : rem;
            default: stk_wdata = alu;
        endcase
    end

    smc_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk     (clk),
        .wr_en   (cmd.stk_wr),
        .wr_addr (sp_reg[STACK_AW-1:0]),
        .wr_data (stk_wdata),
        .rd_en   (cmd.stk_rd),
        .rd_addr (stk_raddr[STACK_AW-1:0]),
        .rd_data (stk_rdata)
    );

    smc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (x_reg),
        .divisor   (y_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        case (op_reg[4:0])
            OP_ADD:  alu = x_reg + y_reg;
            OP_SUB:  alu = x_reg - y_reg;
            OP_MUL:  alu = x_reg * y_reg;
            OP_EQ:   alu = WORD_W'(x_reg == y_reg);
            OP_GT:   alu = WORD_W'($signed(x_reg) > $signed(y_reg));
            OP_LT:   alu = WORD_W'($signed(x_reg) < $signed(y_reg));
            OP_GEQ:  alu = WORD_W'($signed(x_reg) >= $signed(y_reg));
            OP_LEQ:  alu = WORD_W'($signed(x_reg) <= $signed(y_reg));
            default: alu = '0;
        endcase
    end

    assign stat.mode     = req_reg.mode;
    assign stat.op       = op_reg[4:0];
    assign stat.op_small = ~|op_reg[WORD_W-1:5];
    assign stat.pc_end   = pc_reg >= eff_len;
    assign stat.sp_zero  = sp_reg == '0;
    assign stat.sp_one   = sp_reg == SP_W'(1);
    assign stat.sp_full  = sp_reg == SP_W'(STACK_DEPTH);
    assign stat.jump_bad = arg_reg[WORD_W-1] || (|arg_reg[WORD_W-2:PC_W])
                           || (arg_reg[PC_W-1:0] >= eff_len);
    assign stat.rd_zero  = stk_rdata == '0;
    assign stat.y_zero   = y_reg == '0;
    assign stat.div_done = div_done;

    assign rsp_data = rsp_reg;
endmodule

/* sv/smc_ctrl.sv */
// Controller state machine of the stack machine: sequences fetch, stack access,
// execution and the response handshake. Depends on smc_pkg.
module smc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  smc_pkg::stat_t stat,
    output smc_pkg::cmd_t  cmd
);
    import smc_pkg::*;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free, is_bin, is_arg, op_known, take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign op_known = stat.op_small;
    assign is_bin   = op_known && (stat.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                                                  OP_EQ, OP_GT, OP_LT, OP_GEQ, OP_LEQ});
    assign is_arg   = op_known && (stat.op inside {OP_PSH, OP_JMP, OP_JZ, OP_JNZ});
    assign take     = (stat.op == OP_JZ) == stat.rd_zero;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.mode == MODE_EXEC && !stat.pc_end)
                begin
                    state_next = S_OP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_OP:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_DONE;
                if (is_arg)
                begin
                    if (!stat.pc_end)
                    begin
                        state_next = S_ARG;
                    end
                end
                else if (op_known && stat.op == OP_DUP)
                begin
                    if (!stat.sp_zero && !stat.sp_full)
                    begin
                        state_next = S_DUP;
                    end
                end
                else if (is_bin)
                begin
                    if (!stat.sp_zero && !stat.sp_one)
                    begin
                        state_next = S_RDY;
                    end
                end
                else if (op_known && stat.op == OP_PRN)
                begin
                    if (!stat.sp_zero)
                    begin
                        state_next = S_PRN;
                    end
                end
            end
            S_ARG:
            begin
                state_next = S_ARG2;
            end
            S_ARG2:
            begin
                state_next = S_DONE;
                if ((stat.op == OP_JZ || stat.op == OP_JNZ) && !stat.sp_zero)
                begin
                    state_next = S_JT;
                end
            end
            S_RDY:
            begin
                state_next = S_RDX;
            end
            S_RDX:
            begin
                state_next = S_ALU;
            end
            S_ALU:
            begin
                state_next = S_DONE;
                if ((stat.op == OP_DIV || stat.op == OP_MOD) && !stat.y_zero)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_JT, S_DUP, S_PRN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.wr_sel = WS_ALU;
        case (state_reg)
            S_IDLE:
            begin
                cmd.start = req_valid;
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    MODE_WRITE:
                    begin
                        cmd.prog_wr = 1'b1;
                    end
                    MODE_CLEAR:
                    begin
                        cmd.pc_clear = 1'b1;
                    end
                    MODE_EXEC:
                    begin
                        if (stat.pc_end)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_END;
                        end
                        else
                        begin
                            cmd.prog_rd = 1'b1;
                            cmd.pc_inc  = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.start = 1'b0;
                    end
                endcase
            end
            S_OP:
            begin
                cmd.latch_op = 1'b1;
            end
            S_DEC:
            begin
                if (op_known && stat.op == OP_HLT)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_HALT;
                end
                else if (is_arg)
                begin
                    if (stat.pc_end)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_END;
                    end
                    else
                    begin
                        cmd.prog_rd = 1'b1;
                        cmd.pc_inc  = 1'b1;
                    end
                end
                else if (op_known && stat.op == OP_DUP)
                begin
                    if (stat.sp_zero)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_UNF;
                    end
                    else if (stat.sp_full)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_OVF;
                    end
                    else
                    begin
                        cmd.stk_rd = 1'b1;
                    end
                end
                else if (is_bin)
                begin
                    if (stat.sp_zero || stat.sp_one)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_UNF;
                        cmd.sp_dec      = stat.sp_one;
                    end
                    else
                    begin
                        cmd.stk_rd = 1'b1;
                    end
                end
                else if (op_known && stat.op == OP_PRN)
                begin
                    if (stat.sp_zero)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_UNF;
                    end
                    else
                    begin
                        cmd.stk_rd = 1'b1;
                        cmd.sp_dec = 1'b1;
                    end
                end
            end
            S_ARG:
            begin
                cmd.latch_arg = 1'b1;
            end
            S_ARG2:
            begin
                if (stat.op == OP_PSH)
                begin
                    if (stat.sp_full)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_OVF;
                    end
                    else
                    begin
                        cmd.stk_wr = 1'b1;
                        cmd.wr_sel = WS_ARG;
                        cmd.sp_inc = 1'b1;
                    end
                end
                else if (stat.op == OP_JMP)
                begin
                    if (stat.jump_bad)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_JMP;
                    end
                    else
                    begin
                        cmd.pc_load = 1'b1;
                    end
                end
                else if (stat.sp_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_UNF;
                end
                else
                begin
                    cmd.stk_rd = 1'b1;
                    cmd.sp_dec = 1'b1;
                end
            end
            S_JT:
            begin
                if (take)
                begin
                    if (stat.jump_bad)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_JMP;
                    end
                    else
                    begin
                        cmd.pc_load = 1'b1;
                    end
                end
            end
            S_DUP:
            begin
                cmd.stk_wr = 1'b1;
                cmd.wr_sel = WS_STK;
                cmd.sp_inc = 1'b1;
            end
            S_PRN:
            begin
                cmd.print_set = 1'b1;
            end
            S_RDY:
            begin
                cmd.latch_y       = 1'b1;
                cmd.stk_rd        = 1'b1;
                cmd.stk_rd_second = 1'b1;
            end
            S_RDX:
            begin
                cmd.latch_x = 1'b1;
                cmd.sp_dec2 = 1'b1;
            end
            S_ALU:
            begin
                if (stat.op == OP_DIV || stat.op == OP_MOD)
                begin
                    if (stat.y_zero)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DIV0;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                    end
                end
                else
                begin
                    cmd.stk_wr = 1'b1;
                    cmd.sp_inc = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.wr_sel = WS_DIV;
                cmd.stk_wr = stat.div_done;
                cmd.sp_inc = stat.div_done;
            end
            S_DONE:
            begin
                cmd.rsp_load = out_free;
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
endmodule

/* sv/stack_machine_core_top.sv */
// Top level of the 32-bit stack machine core.
// Depends on smc_pkg, smc_ctrl and smc_datapath.
//
// Requests arrive on req_valid/req_stall/req_data; each accepted beat gives
// exactly one response beat on rsp_valid/rsp_stall/rsp_data.
// A request writes one program word, clears the program counter, executes one
// instruction at the program counter, or, with the unused mode 3, only responds.
// The program length register is written through cfg_write_enable and
// cfg_write_data; the user must do so only while the core is idle, which
// the core does not enforce. A write or pc clear goes from dispatch straight
// to done; an execute also fetches, decodes and reads the stack memory as its
// opcode needs, and DIV and MOD then wait on the bit-serial divider.
// One request is in flight at a time; the next is accepted as soon as the
// response is loaded into the output register, even while it waits there.
// When the receiver stalls, a finished response holds in the output register
// and the core stops before loading the next one.
// Reset clears the program counter, stack pointer and program length; the
// program and stack memories are not cleared.
module stack_machine_core_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  smc_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output smc_pkg::rsp_t rsp_data,
    input  logic          cfg_write_enable,
    input  logic [10:0]   cfg_write_data
);
    import smc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    smc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    smc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_data         (req_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .cmd              (cmd),
        .stat             (stat),
        .rsp_data         (rsp_data)
    );
endmodule

/* test/stack_machine_core_top_tb.sv */
// Self-checking testbench for stack_machine_core_top: loads directed and random
// programs, runs them beat by beat, and checks every response against a scoreboard.
// Depends on smc_pkg and the stack machine core RTL.
module stack_machine_core_top_tb;
    import smc_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    class vm_scoreboard;
        bit [31:0] prog_mem[PROG_DEPTH];
        bit [31:0] opnd[STACK_DEPTH];
        int unsigned sp;
        bit [31:0] pc;
        int unsigned plen;
        bit [2:0] status;
        rsp_t expected_q[$];
        int fails;

        function int unsigned valid_len();
            return (plen > PROG_DEPTH) ? PROG_DEPTH : plen;
        endfunction

        function bit fetch(output bit [31:0] w);
            w = '0;
            if (status != ST_RUN)
            begin
                return 1'b0;
            end
            if (pc >= valid_len())
            begin
                status = ST_END;
                return 1'b0;
            end
            w = prog_mem[pc];
            pc++;
            return 1'b1;
        endfunction

        function void push(bit [31:0] v);
            if (status != ST_RUN)
            begin
                return;
            end
            if (sp >= STACK_DEPTH)
            begin
                status = ST_OVF;
                return;
            end
            opnd[sp] = v;
            sp++;
        endfunction

        function bit [31:0] pop();
            if (status != ST_RUN)
            begin
                return '0;
            end
            if (sp == 0)
            begin
                status = ST_UNF;
                return '0;
            end
            sp--;
            return opnd[sp];
        endfunction

        function void jump(bit [31:0] t);
            if ($signed(t) < 0 || $signed(t) >= int'(valid_len()))
            begin
                status = ST_JMP;
                return;
            end
            pc = t;
        endfunction

        function void note_request(req_t r);
            bit [31:0] op, a, x, y, res;
            longint sx, sy;
            bit pv;
            bit [31:0] pval;
            rsp_t e;
            status = ST_RUN;
            pv = 1'b0;
            pval = '0;
            if (r.mode == MODE_WRITE)
            begin
                prog_mem[r.address] = r.word;
            end
            else if (r.mode == MODE_CLEAR)
            begin
                pc = '0;
            end
            else if (r.mode == MODE_EXEC && fetch(op))
            begin
                case (op)
                    OP_HLT: status = ST_HALT;
                    OP_PSH:
                    begin
                        if (fetch(a))
                        begin
                            push(a);
                        end
                    end
                    OP_DUP:
                    begin
                        a = pop();
                        push(a);
                        push(a);
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                    OP_EQ, OP_GT, OP_LT, OP_GEQ, OP_LEQ:
                    begin
                        y = pop();
                        x = pop();
                        if (status == ST_RUN)
                        begin
                            sx = longint'($signed(x));
                            sy = longint'($signed(y));
                            res = '0;
                            case (op)
                                OP_ADD: res = x + y;
                                OP_SUB: res = x - y;
                                OP_MUL: res = x * y;
                                OP_DIV, OP_MOD:
                                begin
                                    if (y == 0)
                                    begin
                                        status = ST_DIV0;
                                    end
                                    else if (op == OP_DIV)
                                    begin
                                        res = 32'(sx / sy);
                                    end
                                    else
                                    begin
                                        res = 32'(sx % sy);
                                    end
                                end
                                OP_EQ: res = 32'(sx == sy);
                                OP_GT: res = 32'(sx > sy);
                                OP_LT: res = 32'(sx < sy);
                                OP_GEQ: res = 32'(sx >= sy);
                                default: res = 32'(sx <= sy);
                            endcase
                            push(res);
                        end
                    end
                    OP_PRN:
                    begin
                        a = pop();
                        if (status == ST_RUN)
                        begin
                            pv = 1'b1;
                            pval = a;
                        end
                    end
                    OP_JMP:
                    begin
                        if (fetch(a))
                        begin
                            jump(a);
                        end
                    end
                    OP_JZ, OP_JNZ:
                    begin
                        if (fetch(a))
                        begin
                            x = pop();
                            if (status == ST_RUN && ((op == OP_JZ) == (x == 0)))
                            begin
                                jump(a);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            e.status = status;
            e.print_valid = pv;
            e.print_value = pval;
            e.program_counter = pc[10:0];
            e.stack_depth = sp[8:0];
            expected_q = {expected_q, e};
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response beat with no request outstanding");
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                fails++;
            end
            if (got.print_valid !== e.print_valid)
            begin
                $error("print_valid: expected %0d, got %0d", e.print_valid, got.print_valid);
                fails++;
            end
            if (got.print_value !== e.print_value)
            begin
                $error("print_value: expected %0d, got %0d", e.print_value, got.print_value);
                fails++;
            end
            if (got.program_counter !== e.program_counter)
            begin
                $error("program_counter: expected %0d, got %0d",
                       e.program_counter, got.program_counter);
                fails++;
            end
            if (got.stack_depth !== e.stack_depth)
            begin
                $error("stack_depth: expected %0d, got %0d", e.stack_depth, got.stack_depth);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_data;
    logic        cfg_write_enable = 1'b0;
    logic [10:0] cfg_write_data = '0;

    vm_scoreboard sb = new();
    bit idle_on = 1'b1;
    int item_count = 0;
    bit [31:0] program_words[$];

    stack_machine_core_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data(cfg_write_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_response(rsp_data);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic req_t mk_req(logic [1:0] m, logic [9:0] addr, logic [31:0] w);
        req_t r;
        r.mode = m;
        r.address = addr;
        r.word = w;
        return r;
    endfunction

    task automatic send_req(input req_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.note_request(r);
        item_count++;
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length(input int unsigned len);
        wait_drain();
        cfg_write_enable <= 1'b1;
        cfg_write_data <= len[10:0];
        @(posedge clk);
        sb.plen = len;
        cfg_write_enable <= 1'b0;
    endtask

    task automatic load_program();
        foreach (program_words[i])
        begin
            send_req(mk_req(MODE_WRITE, i[9:0], program_words[i]));
        end
    endtask

    function automatic bit [31:0] pick_operand();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 9));
            2: return -32'($urandom_range(1, 9));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic bit [31:0] pick_target(int len);
        case ($urandom_range(0, 9))
            0: return 32'(len);
            1: return 32'hffff_ffff;
            2: return $urandom();
            default: return 32'($urandom_range(0, len - 1));
        endcase
    endfunction

    task automatic gen_program(input int len, input bit pushy);
        bit [31:0] op;
        program_words.delete();
        while (program_words.size() < len)
        begin
            if ($urandom_range(0, 99) < (pushy ? 60 : 30))
            begin
                op = 32'(OP_PSH);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                op = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(17, 31));
            end
            else
            begin
                op = 32'($urandom_range(0, 16));
            end
            program_words = {program_words, op};
            if (program_words.size() < len)
            begin
                if (op == OP_PSH)
                begin
                    program_words = {program_words, pick_operand()};
                end
                else if (op == OP_JMP || op == OP_JZ || op == OP_JNZ)
                begin
                    program_words = {program_words, pick_target(len)};
                end
            end
        end
    endtask

    task automatic run_program(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 8)
            begin
                send_req(mk_req(MODE_CLEAR, 10'($urandom()), $urandom()));
            end
            else if (k < 11)
            begin
                send_req(mk_req(MODE_SPARE, 10'($urandom()), $urandom()));
            end
            else if (k < 14)
            begin
                send_req(mk_req(MODE_WRITE, 10'($urandom()), $urandom()));
            end
            else
            begin
                send_req(mk_req(MODE_EXEC, 10'($urandom()), $urandom()));
            end
        end
    endtask

    task automatic random_phase(input int len, input bit pushy);
        gen_program(len, pushy);
        load_program();
        set_length(($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len);
        send_req(mk_req(MODE_CLEAR, '0, '0));
        run_program($urandom_range(len, 3 * len + 10));
    endtask

    task automatic run_top_of_memory();
        send_req(mk_req(MODE_CLEAR, '0, '0));
        repeat (6) send_req(mk_req(MODE_EXEC, '0, '0));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_length(0);
        send_req(mk_req(MODE_EXEC, '0, '0));
        send_req(mk_req(MODE_SPARE, 10'h3ff, 32'hffff_ffff));
        send_req(mk_req(MODE_CLEAR, '0, '0));
        send_req(mk_req(MODE_WRITE, 10'h3ff, 32'h8000_0000));
        send_req(mk_req(MODE_WRITE, 10'h3ff, 32'h7fff_ffff));

        program_words = '{32'(OP_PSH), 32'h7fff_ffff, 32'(OP_PSH), 32'd1, 32'(OP_ADD),
                          32'(OP_DUP), 32'(OP_PSH), 32'hffff_ffff, 32'(OP_DIV),
                          32'(OP_PSH), 32'hffff_ffff, 32'(OP_MOD), 32'(OP_DIV),
                          32'(OP_PRN), 32'(OP_PSH), 32'd5, 32'(OP_DUP), 32'(OP_SUB),
                          32'(OP_JZ), 32'd22, 32'(OP_HLT), 32'd17, 32'(OP_PSH),
                          32'hffff_fffd, 32'(OP_PSH), 32'd2, 32'(OP_MUL), 32'(OP_PRN),
                          32'(OP_JMP), 32'hffff_ffff, 32'(OP_JNZ)};
        load_program();
        set_length(31);
        repeat (26) send_req(mk_req(MODE_EXEC, '0, '0));
        send_req(mk_req(MODE_CLEAR, '0, '0));
        repeat (3) send_req(mk_req(MODE_EXEC, '0, '0));

        while (item_count < 600)
        begin
            random_phase($urandom_range(2, 40), $urandom_range(0, 2) == 0);
        end

        send_req(mk_req(MODE_WRITE, 10'd0, 32'(OP_JMP)));
        send_req(mk_req(MODE_WRITE, 10'd1, 32'd1018));
        send_req(mk_req(MODE_WRITE, 10'd1018, 32'(OP_PSH)));
        send_req(mk_req(MODE_WRITE, 10'd1019, 32'd7));
        send_req(mk_req(MODE_WRITE, 10'd1020, 32'(OP_PRN)));
        send_req(mk_req(MODE_WRITE, 10'd1021, 32'(OP_JMP)));
        send_req(mk_req(MODE_WRITE, 10'd1022, 32'd1024));
        send_req(mk_req(MODE_WRITE, 10'd1023, 32'(OP_JMP)));
        set_length(2047);
        run_top_of_memory();
        set_length(PROG_DEPTH);
        run_top_of_memory();

        wait_drain();
        idle_on = 1'b0;
        random_phase(24, 1'b0);

        wait_drain();
        repeat (60) @(posedge clk);
        if (sb.fails == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* files.f */
sv/smc_pkg.sv
sv/smc_ram.sv
sv/smc_divider.sv
sv/smc_datapath.sv
sv/smc_ctrl.sv
sv/stack_machine_core_top.sv
test/stack_machine_core_top_tb.sv
